>>> src/hpk_pkg.sv
`timescale 1ns / 1ps

package hpk_pkg;

  // Table size; only entries that have a weight register exist
  localparam int NUM_ENTRIES = 4;
  localparam int WEIGHT_REGS = 4;
  localparam int ENTRIES     = (NUM_ENTRIES < WEIGHT_REGS) ? NUM_ENTRIES : WEIGHT_REGS;

  localparam int ENT_W    = 64;
  localparam int SEQ_W    = 32;
  localparam int CHANCE_W = 7;
  localparam int WEIGHT_W = 16;
  localparam int TOTAL_W  = 18;
  localparam int ROLL_W   = 14;
  localparam int INDEX_W  = 2;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CHANCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT0 = 3'd1;

  localparam logic [63:0] MIX_GAMMA  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_M1     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_M2     = 64'h94d049bb133111eb;
  localparam logic [31:0] SEQ_OFFSET = 32'h85ebca6b;

  localparam logic [13:0] CHANCE_RANGE = 14'd100;
  localparam logic [13:0] ACTION_RANGE = 14'd10000;

  typedef struct packed {
    logic                       valid;
    logic [1:0][ENT_W-1:0]      mix;
  } hpk_mix_t;

  typedef struct packed {
    logic              valid;
    logic              pass;
    logic [ROLL_W-1:0] roll;
  } hpk_roll_t;

  typedef struct packed {
    logic              valid;
    logic              pass;
    logic [ROLL_W-1:0] cursor;
  } hpk_cursor_t;

endpackage

>>> src/hpk_if.sv
`timescale 1ns / 1ps

interface hpk_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] entity_id;
  logic [31:0] sequence_number;

  modport source (output valid, output entity_id, output sequence_number, input ready);
  modport sink (input valid, input entity_id, input sequence_number, output ready);
endinterface

interface hpk_rsp_if;
  logic       valid;
  logic       ready;
  logic       action_issued;
  logic [1:0] action_index;

  modport source (output valid, output action_issued, output action_index, input ready);
  modport sink (input valid, input action_issued, input action_index, output ready);
endinterface

>>> src/hpk_hash.sv
`timescale 1ns / 1ps

module hpk_hash (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [hpk_pkg::ENT_W-1:0]     entity_id,
  input  logic [hpk_pkg::SEQ_W-1:0]     sequence_number,
  output hpk_pkg::hpk_mix_t             mix_out
);
  import hpk_pkg::*;

  logic [4:0]       vld;
  logic [63:0]      x1   [2];
  logic [63:0]      ll1  [2];
  logic [31:0]      c1a  [2];
  logic [31:0]      c1b  [2];
  logic [63:0]      y    [2];
  logic [63:0]      ll2  [2];
  logic [31:0]      c2a  [2];
  logic [31:0]      c2b  [2];
  logic [63:0]      z    [2];

  logic [31:0] seq_mix [2];
  logic [63:0] x0_next [2];
  logic [63:0] y_sum   [2];
  logic [63:0] z_sum   [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      // Offset sequence wraps in 32 bits before widening
      seq_mix[l] = sequence_number + ((l == 1) ? SEQ_OFFSET : 32'd0);
      x0_next[l] = entity_id ^ (64'(seq_mix[l]) + MIX_GAMMA);
      y_sum[l]   = ll1[l] + {c1a[l] + c1b[l], 32'd0};
      z_sum[l]   = ll2[l] + {c2a[l] + c2b[l], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  // Low 64 bits of each product from three 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        x1[l]  <= x0_next[l] ^ (x0_next[l] >> 30);
        ll1[l] <= 64'(x1[l][31:0]) * 64'(MIX_M1[31:0]);
        c1a[l] <= x1[l][63:32] * MIX_M1[31:0];
        c1b[l] <= x1[l][31:0] * MIX_M1[63:32];
        y[l]   <= y_sum[l] ^ (y_sum[l] >> 27);
        ll2[l] <= 64'(y[l][31:0]) * 64'(MIX_M2[31:0]);
        c2a[l] <= y[l][63:32] * MIX_M2[31:0];
        c2b[l] <= y[l][31:0] * MIX_M2[63:32];
        z[l]   <= z_sum[l] ^ (z_sum[l] >> 31);
      end
    end
  end

  assign mix_out.valid  = vld[4];
  assign mix_out.mix[0] = z[0];
  assign mix_out.mix[1] = z[1];

endmodule

>>> src/hpk_reduce.sv
`timescale 1ns / 1ps

module hpk_reduce (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  hpk_pkg::hpk_mix_t              mix_in,
  input  logic [hpk_pkg::CHANCE_W-1:0]   chance_percent,
  output hpk_pkg::hpk_roll_t             roll_out
);
  import hpk_pkg::*;

  localparam int RECIP_SHIFT = 38;
  localparam logic [13:0] MODS [2] = '{CHANCE_RANGE, ACTION_RANGE};
  // 2^(16*i) mod m for each 16-bit chunk
  localparam logic [13:0] RES [2][4] = '{
    '{14'd1, 14'(64'(1 << 16) % 64'd100), 14'(64'h1_0000_0000 % 64'd100),
      14'(64'h1_0000_0000_0000 % 64'd100)},
    '{14'd1, 14'(64'(1 << 16) % 64'd10000), 14'(64'h1_0000_0000 % 64'd10000),
      14'(64'h1_0000_0000_0000 % 64'd10000)}};
  localparam logic [31:0] RECIP [2] = '{
    32'(64'h40_0000_0000 / 64'd100), 32'(64'h40_0000_0000 / 64'd10000)};

  logic [2:0]  vld;
  logic [31:0] r1 [2];
  logic [31:0] r2 [2];
  logic [25:0] q2 [2];
  logic [13:0] rem3 [2];

  logic [31:0] r1_next   [2];
  logic [63:0] prod      [2];
  logic [31:0] rem_raw   [2];
  logic [31:0] rem_fix   [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      r1_next[l] = '0;
      for (int i = 0; i < 4; i++) begin
        r1_next[l] = r1_next[l] + 32'(mix_in.mix[l][16*i +: 16]) * 32'(RES[l][i]);
      end
      prod[l]    = 64'(r1[l]) * 64'(RECIP[l]);
      // Estimate is at most one short: one correction step
      rem_raw[l] = r2[l] - 32'(q2[l]) * 32'(MODS[l]);
      rem_fix[l] = (rem_raw[l] >= 32'(MODS[l])) ? rem_raw[l] - 32'(MODS[l]) : rem_raw[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], mix_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        r1[l]   <= r1_next[l];
        r2[l]   <= r1[l];
        q2[l]   <= 26'(prod[l] >> RECIP_SHIFT);
        rem3[l] <= 14'(rem_fix[l]);
      end
    end
  end

  assign roll_out.valid = vld[2];
  assign roll_out.pass  = rem3[0] < 14'(chance_percent);
  assign roll_out.roll  = rem3[1];

endmodule

>>> src/hpk_divmod.sv
`timescale 1ns / 1ps

module hpk_divmod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  hpk_pkg::hpk_roll_t            roll_in,
  input  logic [hpk_pkg::TOTAL_W-1:0]   total,
  output hpk_pkg::hpk_cursor_t          cursor_out
);
  import hpk_pkg::*;

  localparam int STEPS = 5;
  localparam int NSTAGE = (ROLL_W + STEPS - 1) / STEPS;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] pass;
  logic [ROLL_W-1:0] rem      [NSTAGE];
  logic [ROLL_W-1:0] rem_next [NSTAGE];

  // Restoring remainder, STEPS quotient bits per stage, top bit first
  always_comb begin
    logic [ROLL_W-1:0] tmp;
    logic [31:0]       sh;
    for (int s = 0; s < NSTAGE; s++) begin
      tmp = (s == 0) ? roll_in.roll : rem[(s == 0) ? 0 : s - 1];
      for (int b = ROLL_W - 1; b >= 0; b--) begin
        sh = 32'(total) << b;
        if ((ROLL_W - 1 - b) / STEPS == s && 32'(tmp) >= sh) begin
          tmp = ROLL_W'(32'(tmp) - sh);
        end
      end
      rem_next[s] = tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], roll_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass <= {pass[NSTAGE-2:0], roll_in.pass};
      for (int s = 0; s < NSTAGE; s++) begin
        rem[s] <= rem_next[s];
      end
    end
  end

  assign cursor_out.valid  = vld[NSTAGE-1];
  assign cursor_out.pass   = pass[NSTAGE-1];
  assign cursor_out.cursor = rem[NSTAGE-1];

endmodule

>>> src/hashed_weighted_action_picker.sv
`timescale 1ns / 1ps

// Hashed weighted action picker.
// req beats carry entity_id and sequence_number; each one yields exactly one
// rsp beat with action_issued and action_index, in order. The pair is mixed
// by a 64-bit finalizer; the mix modulo 100 is checked against chance_percent
// and a second mix (sequence offset) modulo 10000, then modulo the weight
// total, walks the weight table to pick an entry. action_index is 0 whenever
// nothing is issued.
// Configuration: cfg_wr_en/cfg_index/cfg_wr_data, index 0 = chance_percent,
// 1..4 = weight_0..weight_3; other indexes are ignored. Write only while idle.
// Pipeline: 5 hash stages, 3 modulo stages, 3 weight-remainder stages and 1
// output register.
// Throughput: one beat per cycle while rsp does not stall; the two 64-bit
// multiplies per hash each take a partial-product stage and a summing stage.
// Reset clears the valid bits, configuration and weight sums; rsp.valid drops.
// When rsp stalls, the whole pipeline holds: req.ready = !rsp.valid | rsp.ready.
module hashed_weighted_action_picker (
  input  logic                              clk,
  input  logic                              rst,
  hpk_req_if.sink                           req,
  hpk_rsp_if.source                         rsp,
  input  logic                              cfg_wr_en,
  input  logic [hpk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hpk_pkg::WEIGHT_W-1:0]      cfg_wr_data
);
  import hpk_pkg::*;

  logic [CHANCE_W-1:0] chance_percent;
  logic [WEIGHT_W-1:0] weight [WEIGHT_REGS];
  logic [TOTAL_W-1:0]  prefix [ENTRIES+1];
  logic [TOTAL_W-1:0]  prefix_next [ENTRIES+1];

  logic               en;
  hpk_mix_t           mix;
  hpk_roll_t          roll;
  hpk_cursor_t        cur;

  logic               out_valid;
  logic               out_issued;
  logic [INDEX_W-1:0] out_index;
  logic [INDEX_W-1:0] pick_next;

  // Advance every stage together unless the output beat is stuck
  assign en        = !out_valid || rsp.ready;
  assign req.ready = en;

  // Config registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      chance_percent <= '0;
      for (int i = 0; i < WEIGHT_REGS; i++) begin
        weight[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_CHANCE) begin
        chance_percent <= cfg_wr_data[CHANCE_W-1:0];
      end
      for (int i = 0; i < WEIGHT_REGS; i++) begin
        if (cfg_index == REG_WEIGHT0 + CFG_IDX_W'(i)) begin
          weight[i] <= cfg_wr_data;
        end
      end
    end
  end

  // Running sums of the weights; last one is the total
  always_comb begin
    prefix_next[0] = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      prefix_next[i+1] = prefix_next[i] + TOTAL_W'(weight[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= ENTRIES; i++) begin
        prefix[i] <= '0;
      end
    end else begin
      for (int i = 0; i <= ENTRIES; i++) begin
        prefix[i] <= prefix_next[i];
      end
    end
  end

  hpk_hash u_hash (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (req.valid),
    .entity_id       (req.entity_id),
    .sequence_number (req.sequence_number),
    .mix_out         (mix)
  );

  hpk_reduce u_reduce (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .mix_in         (mix),
    .chance_percent (chance_percent),
    .roll_out       (roll)
  );

  hpk_divmod u_divmod (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .roll_in    (roll),
    .total      (prefix[ENTRIES]),
    .cursor_out (cur)
  );

  // First entry whose running sum exceeds the cursor; zero-weight entries
  // can never satisfy that before a nonzero one does
  always_comb begin
    pick_next = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (TOTAL_W'(cur.cursor) < prefix[i+1]) begin
        pick_next = INDEX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cur.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_issued <= cur.pass && (prefix[ENTRIES] != '0);
      out_index  <= (cur.pass && (prefix[ENTRIES] != '0)) ? pick_next : '0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.action_issued = out_issued;
  assign rsp.action_index  = out_index;

endmodule

>>> src/hpk_checker.sv
`timescale 1ns / 1ps

module hpk_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_issued,
  input logic [1:0] out_index
);

  // Stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_issued) && $stable(out_index))
    else $error("rsp beat changed under stall");

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_issued |-> out_index == 2'd0)
    else $error("index nonzero with no action");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("req.ready does not follow the output stage");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("rsp.valid high right after reset");

endmodule

bind hashed_weighted_action_picker hpk_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_issued (rsp.action_issued),
  .out_index  (rsp.action_index)
);
